@@ rtl/branch_history_predictor_macros.svh @@
// ----------------------------------------------------------------------------
// branch history predictor assertion macros
// concurrent checks, all clocked on clk; compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef BRANCH_HISTORY_PREDICTOR_MACROS_SVH
`define BRANCH_HISTORY_PREDICTOR_MACROS_SVH

`ifndef ASSERT_OFF
// check that is ignored while reset is high
`define BHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also spans reset
`define BHP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BHP_ASSERT(lbl, prop, msg)
`define BHP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ rtl/bhp_pkg.sv @@
// ----------------------------------------------------------------------------
// bhp_pkg
// shared types, constants and helpers of the branch history predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bhp_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int MAX_HISTORY   = 16;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FILL_W = $clog2(MAX_HISTORY + 1);
  localparam int ADDR_W = 64;
  localparam int HLEN_W = 5;
  localparam int MODE_W = 2;
  localparam int OP_W   = 2;
  localparam int CIDX_W = 2;

  // request opcodes
  localparam logic [OP_W-1:0] OP_PREDICT = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  // prediction modes (mode three behaves as dynamic)
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STATIC = 2'd1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_PREDICT_MODE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_TEXT_END     = 2'd1;
  localparam logic [CIDX_W-1:0] REG_HISTORY_LEN  = 2'd2;

  localparam logic [HLEN_W-1:0] HISTORY_LEN_RESET = 5'd8;

  typedef struct packed {
    logic [ADDR_W-1:0]      address;
    logic [ADDR_W-1:0]      dest;
    logic [MAX_HISTORY-1:0] history;
    logic [FILL_W-1:0]      fill;
  } entry_t;

  typedef struct packed {
    logic [MODE_W-1:0] predict_mode;
    logic [ADDR_W-1:0] text_end;
    logic [HLEN_W-1:0] history_len;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] pc;
    logic              is_branch;
    logic [7:0]        instr_high_byte;
    logic [ADDR_W-1:0] offset_target;
    logic [ADDR_W-1:0] actual_dest;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] predicted_pc;
    logic              record_hit;
    logic              add_error;
  } res_t;

  // table write and maintenance commands
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
    logic             set_valid;
    logic             clear_all;
    logic             ptr_adv;
  } tbl_cmd_t;

  // unconditional immediate branch: bits 27..24 in 4..7, bits 31..29 zero or four
  function automatic logic is_uncond(input logic [7:0] hb);
    logic lo_ok;
    logic hi_ok;
    lo_ok = (hb[3:2] == 2'b01);
    hi_ok = (hb[6:5] == 2'b00);
    return lo_ok && hi_ok;
  endfunction

  // history length clamped to 1..MAX_HISTORY
  function automatic logic [FILL_W-1:0] eff_len(input logic [HLEN_W-1:0] n);
    logic [FILL_W-1:0] r;
    if (n == '0) begin
      r = FILL_W'(1);
    end else if (int'(n) > MAX_HISTORY) begin
      r = FILL_W'(MAX_HISTORY);
    end else begin
      r = FILL_W'(n);
    end
    return r;
  endfunction

endpackage

@@ rtl/bhp_table.sv @@
// ----------------------------------------------------------------------------
// bhp_table
// entry memory with registered read, per-entry valid bits and replace pointer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhp_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [bhp_pkg::IDX_W-1:0]        rd_idx,
  output bhp_pkg::entry_t                  rd_entry,
  output logic [bhp_pkg::TABLE_ENTRIES-1:0] valid,
  output logic [bhp_pkg::IDX_W-1:0]        ptr,
  input  bhp_pkg::tbl_cmd_t                cmd
);
  import bhp_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  // entry storage, contents undefined until written
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_idx] <= cmd.wr_data;
    end
    rd_entry <= mem[rd_idx];
  end

  // valid bits and round-robin replace pointer
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      valid <= '0;
      ptr   <= '0;
    end else begin
      if (cmd.set_valid) begin
        valid[cmd.wr_idx] <= 1'b1;
      end
      if (cmd.ptr_adv) begin
        if (ptr == IDX_W'(TABLE_ENTRIES - 1)) begin
          ptr <= '0;
        end else begin
          ptr <= ptr + IDX_W'(1);
        end
      end
    end
  end

endmodule

@@ rtl/bhp_core.sv @@
// ----------------------------------------------------------------------------
// bhp_core
// request sequencer: table walk on one shared 64-bit comparator, bit-serial
// history tally and majority vote
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhp_core (
  input  logic                              clk,
  input  logic                              rst,
  input  bhp_pkg::cfg_t                     cfg,
  input  logic                              req_load,
  input  bhp_pkg::req_t                     req_in,
  input  logic                              out_free,
  output logic                              busy,
  output logic                              res_done,
  output bhp_pkg::res_t                     res,
  output bhp_pkg::tbl_cmd_t                 tbl_cmd,
  output logic [bhp_pkg::IDX_W-1:0]         rd_idx,
  input  bhp_pkg::entry_t                   rd_entry,
  input  logic [bhp_pkg::TABLE_ENTRIES-1:0] valid,
  input  logic [bhp_pkg::IDX_W-1:0]         ptr
);
  import bhp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_TALLY  = 9'b000001000,
    S_VOTE   = 9'b000010000,
    S_DIR    = 9'b000100000,
    S_UPD    = 9'b001000000,
    S_ADD    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  req_t                   req;
  logic [ADDR_W-1:0]      pc4;
  logic [IDX_W:0]         scan_cnt;
  logic                   cmp_vld;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic [IDX_W-1:0]       hit_idx;
  entry_t                 hit_ent;
  logic [MAX_HISTORY-1:0] tly_hist;
  logic [FILL_W-1:0]      tly_left;
  logic [FILL_W-1:0]      tly_cnt;
  logic [FILL_W-1:0]      vote_n;

  logic [ADDR_W-1:0] cmp_a;
  logic [ADDR_W-1:0] cmp_b;
  logic              cmp_eq;
  logic              cmp_gt;
  logic [FILL_W-1:0] len_eff;
  logic              match;
  logic              last_cmp;
  logic [FILL_W-1:0] hit_n;
  logic [FILL_W:0]   fill_inc;
  logic [FILL_W-1:0] fill_new;
  logic [FILL_W:0]   vote_two;
  logic [FILL_W:0]   vote_ref;

  assign len_eff  = eff_len(cfg.history_len);
  assign busy     = (state != S_IDLE);
  assign res_done = (state == S_DONE);
  assign rd_idx   = scan_cnt[IDX_W-1:0];

  // shared comparator, operands chosen by the step in progress
  always_comb begin
    case (state)
      S_DECODE: begin
        cmp_a = cfg.text_end;
        cmp_b = req.pc;
      end
      S_SCAN: begin
        cmp_a = rd_entry.address;
        cmp_b = req.pc;
      end
      S_DIR: begin
        cmp_a = hit_ent.dest;
        cmp_b = req.pc;
      end
      S_UPD: begin
        cmp_a = req.actual_dest;
        cmp_b = pc4;
      end
      default: begin
        cmp_a = req.actual_dest;
        cmp_b = req.pc;
      end
    endcase
  end

  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_gt = (cmp_a > cmp_b);

  // walk status
  assign match    = cmp_vld && valid[cmp_idx] && cmp_eq;
  assign last_cmp = cmp_vld && (cmp_idx == IDX_W'(TABLE_ENTRIES - 1));
  assign hit_n    = (rd_entry.fill > len_eff) ? len_eff : rd_entry.fill;

  // fill count after an update, held at the effective length
  assign fill_inc = {1'b0, hit_ent.fill} + (FILL_W + 1)'(1);
  assign fill_new = (fill_inc > {1'b0, len_eff}) ? len_eff : fill_inc[FILL_W-1:0];

  // vote: twice the taken count against the number of outcomes counted
  assign vote_two = {tly_cnt, 1'b0};
  assign vote_ref = {1'b0, vote_n};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_load) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (req.opcode == OP_UPDATE) begin
          state_next = S_SCAN;
        end else if (req.opcode == OP_PREDICT && req.pc != '0 && req.is_branch &&
                     cmp_gt && cfg.predict_mode != MODE_NONE) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (match) begin
          if (req.opcode == OP_UPDATE) begin
            state_next = S_UPD;
          end else if (cfg.predict_mode == MODE_STATIC) begin
            state_next = S_DIR;
          end else begin
            state_next = S_TALLY;
          end
        end else if (last_cmp) begin
          state_next = (req.opcode == OP_UPDATE) ? S_ADD : S_DONE;
        end
      end
      S_TALLY: begin
        if (tly_left == '0) begin
          state_next = S_VOTE;
        end
      end
      S_VOTE: begin
        state_next = (vote_two == vote_ref) ? S_DIR : S_DONE;
      end
      S_DIR, S_UPD, S_ADD: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_load) begin
          req <= req_in;
          pc4 <= req_in.pc + ADDR_W'(4);
          res <= '0;
        end
      end
      S_DECODE: begin
        scan_cnt   <= '0;
        cmp_vld    <= 1'b0;
        free_found <= 1'b0;
        if (req.opcode == OP_PREDICT) begin
          if (req.pc == '0) begin
            res.predicted_pc <= '0;
          end else if (!req.is_branch) begin
            res.predicted_pc <= pc4;
          end else if (!cmp_gt) begin
            res.predicted_pc <= req.pc;
          end else if (cfg.predict_mode == MODE_NONE) begin
            res.predicted_pc <= pc4;
          end
        end
      end
      S_SCAN: begin
        // issue the next read while comparing the previous one
        if (scan_cnt != (IDX_W + 1)'(TABLE_ENTRIES)) begin
          scan_cnt <= scan_cnt + (IDX_W + 1)'(1);
          cmp_vld  <= 1'b1;
        end else begin
          cmp_vld <= 1'b0;
        end
        cmp_idx <= scan_cnt[IDX_W-1:0];
        // lowest free slot seen on the walk
        if (cmp_vld && !valid[cmp_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
        if (match) begin
          res.record_hit <= 1'b1;
          hit_idx  <= cmp_idx;
          hit_ent  <= rd_entry;
          tly_hist <= rd_entry.history;
          tly_left <= hit_n;
          vote_n   <= hit_n;
          tly_cnt  <= '0;
        end else if (last_cmp && req.opcode == OP_PREDICT) begin
          res.predicted_pc <= is_uncond(req.instr_high_byte) ? req.offset_target : pc4;
        end
      end
      S_TALLY: begin
        // one history bit per cycle, newest first
        if (tly_left != '0) begin
          tly_cnt  <= tly_cnt + FILL_W'(tly_hist[0]);
          tly_hist <= tly_hist >> 1;
          tly_left <= tly_left - FILL_W'(1);
        end
      end
      S_VOTE: begin
        if (vote_two > vote_ref) begin
          res.predicted_pc <= hit_ent.dest;
        end else if (vote_two < vote_ref) begin
          res.predicted_pc <= pc4;
        end
      end
      S_DIR: begin
        // backward or equal taken, forward not taken
        res.predicted_pc <= cmp_gt ? pc4 : hit_ent.dest;
      end
      S_ADD: begin
        if (cmp_eq) begin
          res.add_error <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // table writes
  always_comb begin
    tbl_cmd = '0;
    case (state)
      S_DECODE: begin
        tbl_cmd.clear_all = (req.opcode == OP_CLEAR);
      end
      S_UPD: begin
        tbl_cmd.wr_en           = 1'b1;
        tbl_cmd.wr_idx          = hit_idx;
        tbl_cmd.wr_data.address = req.pc;
        tbl_cmd.wr_data.dest    = hit_ent.dest;
        tbl_cmd.wr_data.history = (hit_ent.history << 1) |
                                  MAX_HISTORY'(!cmp_eq);
        tbl_cmd.wr_data.fill    = fill_new;
      end
      S_ADD: begin
        if (!cmp_eq) begin
          tbl_cmd.wr_en           = 1'b1;
          tbl_cmd.wr_idx          = free_found ? free_idx : ptr;
          tbl_cmd.wr_data.address = req.pc;
          tbl_cmd.wr_data.dest    = req.actual_dest;
          tbl_cmd.wr_data.history = '0;
          tbl_cmd.wr_data.fill    = '0;
          tbl_cmd.set_valid       = 1'b1;
          tbl_cmd.ptr_adv         = !free_found;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/branch_history_predictor.sv @@
// ----------------------------------------------------------------------------
// branch_history_predictor
// branch target table with per-entry outcome history and majority vote
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_stall) carries one predict, update or
//   clear item; result channel (out_valid / out_stall) returns exactly one
//   result item per request, in order.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) set
//   predict_mode, text_end and history_len; write them only while idle.
// Sequence:
//   One item at a time. A request goes through a decode step, then a walk
//   of the 16-entry table on the shared 64-bit comparator at one entry per
//   cycle (stops at the first match), then a write or compare step for an
//   update or a static-mode hit, then a hand-off step. A dynamic-mode hit
//   instead tallies up to 16 history bits, closes the count and votes, with
//   a direction step on a tie. Predicts that need no table walk and clears
//   go from decode straight to hand-off. A finished result sits in the
//   output register, so the next item is accepted while out_stall holds the
//   previous one; the walk then waits in its hand-off step until the output
//   register frees up.
// Reset: clears all valid bits, the replace pointer, the output valid and
//   the registers to mode 0, text end 0 and history length 8.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "branch_history_predictor_macros.svh"

module branch_history_predictor (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bhp_pkg::OP_W-1:0]      opcode,
  input  logic [bhp_pkg::ADDR_W-1:0]    pc,
  input  logic                          is_branch,
  input  logic [7:0]                    instr_high_byte,
  input  logic [bhp_pkg::ADDR_W-1:0]    offset_target,
  input  logic [bhp_pkg::ADDR_W-1:0]    actual_dest,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bhp_pkg::ADDR_W-1:0]    predicted_pc,
  output logic                          record_hit,
  output logic                          add_error,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bhp_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [bhp_pkg::ADDR_W-1:0]    cfg_data
);
  import bhp_pkg::*;

  cfg_t                     cfg;
  req_t                     req_in;
  res_t                     res;
  tbl_cmd_t                 tbl_cmd;
  entry_t                   rd_entry;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [IDX_W-1:0]         ptr;
  logic [IDX_W-1:0]         rd_idx;
  logic                     busy;
  logic                     res_done;
  logic                     req_load;
  logic                     out_free;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.predict_mode <= MODE_NONE;
      cfg.text_end     <= '0;
      cfg.history_len  <= HISTORY_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PREDICT_MODE: cfg.predict_mode <= cfg_data[MODE_W-1:0];
        REG_TEXT_END:     cfg.text_end     <= cfg_data;
        REG_HISTORY_LEN:  cfg.history_len  <= cfg_data[HLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request hand-off
  assign in_stall = busy;
  assign req_load = in_valid && !in_stall;

  assign req_in.opcode          = opcode;
  assign req_in.pc              = pc;
  assign req_in.is_branch       = is_branch;
  assign req_in.instr_high_byte = instr_high_byte;
  assign req_in.offset_target   = offset_target;
  assign req_in.actual_dest     = actual_dest;

  bhp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req_load (req_load),
    .req_in   (req_in),
    .out_free (out_free),
    .busy     (busy),
    .res_done (res_done),
    .res      (res),
    .tbl_cmd  (tbl_cmd),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .valid    (valid),
    .ptr      (ptr)
  );

  bhp_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .valid    (valid),
    .ptr      (ptr),
    .cmd      (tbl_cmd)
  );

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_done && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_done && out_free) begin
      predicted_pc <= res.predicted_pc;
      record_hit   <= res.record_hit;
      add_error    <= res.add_error;
    end
  end

  // checks
  `BHP_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "accepted item did not block the request channel")
  `BHP_ASSERT(a_hit_err_excl, out_valid |-> !(record_hit && add_error), "hit and add error together")
  `BHP_ASSERT(a_err_zero_pc, out_valid && add_error |-> predicted_pc == '0, "add error with nonzero prediction")
  `BHP_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result valid right after reset")

endmodule
